FILE: design/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 32;
  localparam int CMD_W      = 3;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY_LIST = 2'd3;

  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_rear;
    logic rotate;
  } dq_ctrl_t;

endpackage

FILE: design/dq_cell.sv
module dq_cell #(
  parameter int IDX        = 0,
  parameter int DEPTH      = dq_pkg::DEPTH,
  parameter int VALUE_BITS = dq_pkg::VALUE_BITS
) (
  input  logic                         clk_i,
  input  dq_pkg::dq_ctrl_t             ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]   count_i,
  input  logic [VALUE_BITS-1:0]        left_i,
  input  logic [VALUE_BITS-1:0]        right_i,
  input  logic [VALUE_BITS-1:0]        head_i,
  input  logic [VALUE_BITS-1:0]        push_i,
  output logic [VALUE_BITS-1:0]        value_o
);

  localparam int CNTW = $clog2(DEPTH + 1);

  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  is_free;
  logic                  is_tail;

  assign is_free = (count_i == CNTW'(IDX));
  assign is_tail = (count_i == CNTW'(IDX + 1));

  always_comb begin
    value_d = value_q;
    if (ctrl_i.push_front) begin
      value_d = left_i;
    end else if (ctrl_i.pop_front) begin
      value_d = right_i;
    end else if (ctrl_i.push_rear && is_free) begin
      value_d = push_i;
    end else if (ctrl_i.rotate) begin
      value_d = is_tail ? head_i : right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

FILE: design/double_ended_queue.sv
// Each accepted push or pop request gives its result in the output register in
// the cycle after acceptance; one request is taken every cycle unless a list
// is in progress or the output stalls. A list of N entries gives N results, one
// per free output cycle, as the cell row rotates one position per result.
// Reset clears the entry count and the output valid; cell contents are not reset.
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH,
  parameter int VALUE_BITS = dq_pkg::VALUE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [dq_pkg::CMD_W-1:0]            command_i,
  input  logic signed [dq_pkg::DATA_W-1:0]    push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dq_pkg::DATA_W-1:0]    result_value_o,
  output logic [dq_pkg::STATUS_W-1:0]         status_o,
  output logic                                last_o
);

  localparam int CNTW   = $clog2(DEPTH + 1);
  localparam int IDXW   = $clog2(DEPTH);
  localparam int DATA_W = dq_pkg::DATA_W;

  logic [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [VALUE_BITS-1:0] push_val;
  logic [DATA_W-1:0]     head_res, rear_res;

  logic [CNTW-1:0] count_q, count_d;
  logic [CNTW-1:0] left_q, left_d;
  logic            busy_q, busy_d;
  logic [CNTW-1:0] count_m1;
  logic [IDXW-1:0] tail_idx;

  logic                          out_valid_q, out_valid_d;
  logic [DATA_W-1:0]             out_value_q, out_value_d;
  logic [dq_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic                          out_last_q, out_last_d;

  logic out_free, accept, full, empty, list_step;
  dq_pkg::dq_ctrl_t ctrl;

  generate
    if (VALUE_BITS >= DATA_W) begin : g_wide
      assign push_val = VALUE_BITS'(push_value_i);
      assign head_res = cell_val[0][DATA_W-1:0];
      assign rear_res = cell_val[tail_idx][DATA_W-1:0];
    end else begin : g_narrow
      assign push_val = push_value_i[VALUE_BITS-1:0];
      assign head_res = {{(DATA_W-VALUE_BITS){1'b0}}, cell_val[0]};
      assign rear_res = {{(DATA_W-VALUE_BITS){1'b0}}, cell_val[tail_idx]};
    end
  endgenerate

  assign count_m1 = count_q - 1'b1;
  assign tail_idx = count_m1[IDXW-1:0];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy_q || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNTW'(DEPTH));
  assign empty      = (count_q == '0);
  assign list_step  = busy_q && out_free;

  assign ctrl.push_front = accept && (command_i == dq_pkg::CMD_PUSH_FRONT) && !full;
  assign ctrl.push_rear  = accept && (command_i == dq_pkg::CMD_PUSH_REAR) && !full;
  assign ctrl.pop_front  = accept && (command_i == dq_pkg::CMD_POP_FRONT) && !empty;
  assign ctrl.rotate     = list_step;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VALUE_BITS-1:0] left_v, right_v;
      if (i == 0) begin : g_first
        assign left_v = push_val;
      end else begin : g_mid_l
        assign left_v = cell_val[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
        assign right_v = cell_val[i];
      end else begin : g_mid_r
        assign right_v = cell_val[i+1];
      end
      dq_cell #(
        .IDX       (i),
        .DEPTH     (DEPTH),
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .count_i(count_q),
        .left_i (left_v),
        .right_i(right_v),
        .head_i (cell_val[0]),
        .push_i (push_val),
        .value_o(cell_val[i])
      );
    end
  endgenerate

  always_comb begin
    count_d      = count_q;
    left_d       = left_q;
    busy_d       = busy_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    if (out_free) begin
      out_valid_d  = 1'b0;
      out_value_d  = '0;
      out_status_d = dq_pkg::ST_OK;
      out_last_d   = 1'b1;
    end
    if (list_step) begin
      out_valid_d = 1'b1;
      out_value_d = head_res;
      out_last_d  = (left_q == CNTW'(1));
      left_d      = left_q - 1'b1;
      busy_d      = (left_q != CNTW'(1));
    end else if (accept) begin
      case (command_i)
        dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
          out_valid_d = 1'b1;
          if (full) begin
            out_status_d = dq_pkg::ST_OVERFLOW;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_REAR: begin
          out_valid_d = 1'b1;
          if (empty) begin
            out_status_d = dq_pkg::ST_UNDERFLOW;
          end else begin
            count_d     = count_q - 1'b1;
            out_value_d = (command_i == dq_pkg::CMD_POP_FRONT) ? head_res : rear_res;
          end
        end
        dq_pkg::CMD_LIST: begin
          if (empty) begin
            out_valid_d  = 1'b1;
            out_status_d = dq_pkg::ST_EMPTY_LIST;
          end else begin
            busy_d = 1'b1;
            left_d = count_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      left_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      left_q      <= left_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign last_o         = out_last_q;

endmodule

FILE: design/dq_checker.sv
module dq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [dq_pkg::CMD_W-1:0]          command_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [dq_pkg::DATA_W-1:0]  result_value_o,
  input logic [dq_pkg::STATUS_W-1:0]       status_o,
  input logic                              last_o
);

  logic in_acc;
  logic single_cmd;
  logic unknown_cmd;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign single_cmd  = (command_i == dq_pkg::CMD_PUSH_FRONT) ||
                       (command_i == dq_pkg::CMD_PUSH_REAR) ||
                       (command_i == dq_pkg::CMD_POP_FRONT) ||
                       (command_i == dq_pkg::CMD_POP_REAR);
  assign unknown_cmd = !single_cmd && (command_i != dq_pkg::CMD_LIST);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_value_o) &&
      $stable(status_o) && $stable(last_o))
    else $error("stalled result changed");

  // Push and pop requests give exactly one result in the next cycle.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && single_cmd |=> out_valid_o && last_o)
    else $error("push or pop request gave no single result");

  // An unknown command gives no result.
  a_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && unknown_cmd |=> !out_valid_o)
    else $error("unknown command produced a result");

  // Error and empty statuses carry a zero value and end the request.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != dq_pkg::ST_OK) |-> (result_value_o == '0) && last_o)
    else $error("status result has a value or no last marker");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .command_i     (command_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_value_o(result_value_o),
  .status_o      (status_o),
  .last_o        (last_o)
);

FILE: dv/tb_double_ended_queue.sv
`timescale 1ns / 100ps

module tb_double_ended_queue;

  typedef struct {
    logic [dq_pkg::DATA_W-1:0]   value;
    logic [dq_pkg::STATUS_W-1:0] status;
    logic                        last;
  } dq_result_t;

  class deque_scoreboard;
    logic [dq_pkg::VALUE_BITS-1:0] cells [dq_pkg::DEPTH];
    int unsigned front_pos;
    int unsigned fill;
    dq_result_t pending_results [$];
    int unsigned errors;

    function new();
      front_pos = 0;
      fill      = 0;
      errors    = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void add_result(logic [dq_pkg::DATA_W-1:0] value,
                             logic [dq_pkg::STATUS_W-1:0] status, logic last);
      dq_result_t r;
      r.value  = value;
      r.status = status;
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    // Works out the results of one accepted request and updates the ring copy.
    function void note_request(logic [dq_pkg::CMD_W-1:0] cmd,
                               logic [dq_pkg::DATA_W-1:0] val);
      int unsigned pos;
      logic [dq_pkg::DATA_W-1:0] popped;
      case (cmd)
        dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_REAR: begin
          if (fill >= dq_pkg::DEPTH) begin
            add_result('0, dq_pkg::ST_OVERFLOW, 1'b1);
          end else begin
            if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
              front_pos = (front_pos + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
              pos = front_pos;
            end else begin
              pos = (front_pos + fill) % dq_pkg::DEPTH;
            end
            cells[pos] = val;
            fill++;
            add_result('0, dq_pkg::ST_OK, 1'b1);
          end
        end
        dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_POP_REAR: begin
          if (fill == 0) begin
            add_result('0, dq_pkg::ST_UNDERFLOW, 1'b1);
          end else begin
            if (cmd == dq_pkg::CMD_POP_FRONT) begin
              popped = cells[front_pos];
              front_pos = (front_pos + 1) % dq_pkg::DEPTH;
            end else begin
              popped = cells[(front_pos + fill - 1) % dq_pkg::DEPTH];
            end
            fill--;
            add_result(popped, dq_pkg::ST_OK, 1'b1);
          end
        end
        dq_pkg::CMD_LIST: begin
          if (fill == 0) begin
            add_result('0, dq_pkg::ST_EMPTY_LIST, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++) begin
              add_result(cells[(front_pos + i) % dq_pkg::DEPTH], dq_pkg::ST_OK,
                         i + 1 == fill);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report(string what, logic [dq_pkg::DATA_W-1:0] got,
                logic [dq_pkg::DATA_W-1:0] want);
      if (errors < 40) begin
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      end
      errors++;
    endtask

    task check_result(logic [dq_pkg::DATA_W-1:0] value,
                      logic [dq_pkg::STATUS_W-1:0] status, logic last);
      dq_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result value", value, '0);
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) report("result value", value, want.value);
        if (status !== want.status) begin
          report("status", dq_pkg::DATA_W'(status), dq_pkg::DATA_W'(want.status));
        end
        if (last !== want.last) begin
          report("last", dq_pkg::DATA_W'(last), dq_pkg::DATA_W'(want.last));
        end
      end
    endtask
  endclass

  logic                             clk_i        = 1'b0;
  logic                             rst_ni       = 1'b0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic [dq_pkg::CMD_W-1:0]         command      = dq_pkg::CMD_LIST;
  logic signed [dq_pkg::DATA_W-1:0] push_value   = '0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic signed [dq_pkg::DATA_W-1:0] result_value;
  logic [dq_pkg::STATUS_W-1:0]      status;
  logic                             last;

  logic [15:0] stall_cycle = '0;
  int          stall_mode  = 0;
  int          burst_left  = 0;

  deque_scoreboard sb = new();

  double_ended_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .push_value_i   (push_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_value_o (result_value),
    .status_o       (status),
    .last_o         (last)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1'b1;
    if (stall_cycle[5:0] == '0) begin
      stall_mode <= $urandom_range(0, 2);
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= (stall_cycle[2:0] != '0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        sb.note_request(command, push_value);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(result_value, status, last);
      end
    end
  end

  task automatic send_request(input logic [dq_pkg::CMD_W-1:0] cmd,
                              input logic [dq_pkg::DATA_W-1:0] val);
    int gap;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    push_value <= val;
    do @(posedge clk_i); while (in_stall);
    burst_left--;
  endtask

  task automatic pause_until_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Runs a stretch of random requests weighted toward filling, draining or a mix.
  task automatic run_phase(int n_items, int push_pct, int pop_pct, int list_pct);
    int r;
    int sent;
    logic [dq_pkg::CMD_W-1:0] cmd;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        cmd = $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_FRONT : dq_pkg::CMD_PUSH_REAR;
        sent++;
      end else if (r < push_pct + pop_pct) begin
        cmd = $urandom_range(0, 1) ? dq_pkg::CMD_POP_FRONT : dq_pkg::CMD_POP_REAR;
        sent++;
      end else if (r < push_pct + pop_pct + list_pct) begin
        cmd = dq_pkg::CMD_LIST;
        sent++;
      end else begin
        cmd = dq_pkg::CMD_LIST + dq_pkg::CMD_W'($urandom_range(1, 3));
      end
      send_request(cmd, $urandom);
    end
  endtask

  initial begin
    logic [dq_pkg::CMD_W-1:0] unknown_cmd;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(dq_pkg::CMD_LIST, $urandom);
    send_request(dq_pkg::CMD_POP_FRONT, $urandom);
    send_request(dq_pkg::CMD_POP_REAR, $urandom);
    send_request(dq_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(dq_pkg::CMD_PUSH_REAR, 32'h8000_0000);
    send_request(dq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    send_request(dq_pkg::CMD_PUSH_REAR, 32'hFFFF_FFFF);
    send_request(dq_pkg::CMD_LIST, $urandom);
    send_request(dq_pkg::CMD_POP_FRONT, $urandom);
    send_request(dq_pkg::CMD_POP_REAR, $urandom);
    unknown_cmd = dq_pkg::CMD_LIST;
    repeat (3) begin
      unknown_cmd++;
      send_request(unknown_cmd, $urandom);
    end
    send_request(dq_pkg::CMD_LIST, $urandom);
    send_request(dq_pkg::CMD_PUSH_REAR, 32'h5555_5555);
    send_request(dq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_request(dq_pkg::CMD_POP_REAR, $urandom);
    send_request(dq_pkg::CMD_POP_FRONT, $urandom);
    send_request(dq_pkg::CMD_POP_FRONT, $urandom);
    send_request(dq_pkg::CMD_POP_REAR, $urandom);
    send_request(dq_pkg::CMD_POP_REAR, $urandom);
    send_request(dq_pkg::CMD_LIST, $urandom);
    pause_until_drained();

    run_phase(90, 88, 6, 4);
    send_request(dq_pkg::CMD_LIST, $urandom);
    pause_until_drained();
    run_phase(90, 8, 88, 2);
    pause_until_drained();
    run_phase(70, 45, 40, 10);
    pause_until_drained();

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: files.f
design/dq_pkg.sv
design/dq_cell.sv
design/double_ended_queue.sv
design/dq_checker.sv
dv/tb_double_ended_queue.sv
